@@ rtl/core/lir_pkg.sv @@
// Package for the linear interpolation resampler.
// Holds the sequencer state type, register indexes and fixed widths.
// No dependencies; linear_interp_resampler and its testbench import it.
package lir_pkg;

	localparam int RATE_STEP_W = 21;
	localparam int CHAN_CNT_W  = 2;
	localparam int FRAC_W      = 16;
	localparam int POS_W       = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_RESULTS = 64;
	localparam int RESULT_CNT_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_FRAME_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_FRAME_COUNT = 2'd3;

	localparam logic [RATE_STEP_W-1:0] RATE_STEP_RESET = 21'd65536;
	localparam logic [CHAN_CNT_W-1:0]  CHAN_CNT_RESET  = 2'd1;
	localparam logic [CHAN_CNT_W-1:0]  CHAN_STEREO     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_L,
		ST_MUL_R,
		ST_FIN,
		ST_LOOK,
		ST_OUT
	} lir_state_t;

endpackage

@@ rtl/core/lir_in_if.sv @@
// Input channel of the resampler: one frame of samples per item.
// Valid/ready handshake; no dependencies.
interface lir_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

@@ rtl/core/lir_out_if.sv @@
// Output channel of the resampler: one interpolated frame per item.
// Valid/ready handshake; no dependencies.
interface lir_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic                          run_last;
	logic                          stream_done;

	modport source (output valid, output out_left, output out_right, output run_last,
		output stream_done, input ready);
	modport sink   (input valid, input out_left, input out_right, input run_last,
		input stream_done, output ready);
endinterface

@@ rtl/core/linear_interp_resampler.sv @@
// Linear interpolation sample-rate converter, one input frame per item.
// A small sequencer steps each output through a single shared multiplier.
// After an accepted frame is evaluated, each output it causes passes in order
// through left product, right product, rounding, lookahead and output register,
// and waits there while the sink holds ready low; at most 64 outputs come from one frame.
// The input is not ready while a frame is being worked on. Outputs sit at
// Q24.16 positions advancing by rate_step; output i is interpolated between
// the previous and the current frame with round to nearest, and on the last
// frame the remaining outputs repeat its samples up to out_frame_count.
// Depends on lir_pkg, lir_in_if and lir_out_if.
module linear_interp_resampler
	import lir_pkg::*;
#(
	parameter int SAMPLE_BITS      = 16,
	parameter int FRAME_COUNT_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [((FRAME_COUNT_BITS > RATE_STEP_W) ? FRAME_COUNT_BITS : RATE_STEP_W)-1:0]
	                                              cfg_data,
	lir_in_if.sink                                in_ch,
	lir_out_if.source                             out_ch
);

	localparam int S    = SAMPLE_BITS;
	localparam int W    = FRAME_COUNT_BITS;
	localparam int POSW = POS_W;
	localparam int PRDW = S + FRAC_W + 2;

	lir_state_t state_q, state_d;

	logic [RATE_STEP_W-1:0] rate_step_q;
	logic [CHAN_CNT_W-1:0]  channel_count_q;
	logic [W-1:0]           in_count_q;
	logic [W-1:0]           out_count_q;

	logic signed [S-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q, yl_q;
	logic signed [S:0]   diff_l_q, diff_r_q;
	logic [W-1:0]        frames_seen_q, outputs_done_q;
	logic [POSW-1:0]     pos_q;
	logic [RESULT_CNT_W-1:0] n_q;
	logic                skip_q, last_q, stereo_q, hold_q, more_q;
	logic signed [PRDW-1:0] prod_q;

	logic signed [S-1:0] out_left_q, out_right_q;
	logic                run_last_q, stream_done_q;

	logic                accept, out_take, more, commit, mul_en;
	logic [W-1:0]        ipos;
	logic [FRAC_W-1:0]   frac;
	logic signed [S:0]   mul_a;
	logic signed [PRDW-1:0] rnd;
	logic signed [S+1:0] q_val;
	logic signed [S-1:0] x0_sel, lerp_y;
	logic [W-1:0]        od_inc;
	logic [RESULT_CNT_W-1:0] n_inc;
	logic [W:0]          k_plus;
	logic                in_stereo;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_take = out_ch.valid && out_ch.ready;
	assign ipos     = W'(pos_q[POSW-1:FRAC_W]);
	assign frac     = pos_q[FRAC_W-1:0];
	assign more     = (outputs_done_q < out_count_q)
		&& (n_q < RESULT_CNT_W'(MAX_RESULTS))
		&& ((ipos < frames_seen_q) || last_q);
	assign k_plus   = {1'b0, frames_seen_q} + {{W{1'b0}}, 1'b1};
	assign in_stereo = (channel_count_q == CHAN_STEREO);

	// Shared multiplier and rounding adder, used for left then right.
	assign mul_a  = (state_q == ST_MUL_L) ? diff_l_q : diff_r_q;
	assign x0_sel = (state_q == ST_MUL_R) ? prev_l_q : prev_r_q;
	assign rnd    = prod_q + PRDW'(32768);
	assign q_val  = (S+2)'(rnd >>> FRAC_W);
	assign lerp_y = x0_sel + q_val[S-1:0];
	assign od_inc = outputs_done_q + {{(W-1){1'b0}}, 1'b1};
	assign n_inc  = n_q + {{(RESULT_CNT_W-1){1'b0}}, 1'b1};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (skip_q || !more) state_d = ST_IDLE;
				else state_d = ST_MUL_L;
			end
			ST_MUL_L: state_d = ST_MUL_R;
			ST_MUL_R: state_d = ST_FIN;
			ST_FIN:   state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_ch.ready) state_d = more_q ? ST_MUL_L : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		commit = 1'b0;
		mul_en = 1'b0;
		case (state_q)
			ST_EVAL:  commit = !skip_q && !more;
			ST_MUL_L: mul_en = 1'b1;
			ST_MUL_R: mul_en = 1'b1;
			ST_OUT:   commit = out_ch.ready && !more_q;
			default: begin
				commit = 1'b0;
				mul_en = 1'b0;
			end
		endcase
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = (state_q == ST_OUT);
	assign out_ch.out_left    = out_left_q;
	assign out_ch.out_right   = out_right_q;
	assign out_ch.run_last    = run_last_q;
	assign out_ch.stream_done = stream_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rate_step_q     <= RATE_STEP_RESET;
			channel_count_q <= CHAN_CNT_RESET;
			in_count_q      <= {{(W-1){1'b0}}, 1'b1};
			out_count_q     <= '0;
			prev_l_q        <= '0;
			prev_r_q        <= '0;
			frames_seen_q   <= '0;
			pos_q           <= '0;
			outputs_done_q  <= '0;
			n_q             <= '0;
			skip_q          <= 1'b0;
			last_q          <= 1'b0;
			stereo_q        <= 1'b0;
			hold_q          <= 1'b0;
			more_q          <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE_STEP:       rate_step_q     <= cfg_data[RATE_STEP_W-1:0];
					REG_CHANNEL_COUNT:   channel_count_q <= cfg_data[CHAN_CNT_W-1:0];
					REG_IN_FRAME_COUNT:  in_count_q      <= cfg_data[W-1:0];
					REG_OUT_FRAME_COUNT: out_count_q     <= cfg_data[W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				skip_q   <= (frames_seen_q >= in_count_q);
				last_q   <= (k_plus == {1'b0, in_count_q});
				stereo_q <= in_stereo;
				n_q      <= '0;
			end
			if (state_q == ST_MUL_L) hold_q <= !(ipos < frames_seen_q);
			if (state_q == ST_FIN) begin
				n_q   <= n_inc;
				pos_q <= pos_q + POSW'(rate_step_q);
				if (od_inc >= out_count_q) outputs_done_q <= od_inc;
				else if (last_q && n_inc == RESULT_CNT_W'(MAX_RESULTS))
					outputs_done_q <= out_count_q;
				else outputs_done_q <= od_inc;
			end
			if (state_q == ST_LOOK) more_q <= more;
			if (commit) begin
				prev_l_q      <= cur_l_q;
				prev_r_q      <= cur_r_q;
				frames_seen_q <= k_plus[W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_l_q  <= in_ch.sample_left;
			cur_r_q  <= in_stereo ? in_ch.sample_right : '0;
			diff_l_q <= (S+1)'(in_ch.sample_left) - (S+1)'(prev_l_q);
			diff_r_q <= (in_stereo ? (S+1)'(in_ch.sample_right) : '0) - (S+1)'(prev_r_q);
		end
		if (mul_en) prod_q <= PRDW'(mul_a * $signed({1'b0, frac}));
		if (state_q == ST_MUL_R) yl_q <= hold_q ? cur_l_q : lerp_y;
		if (state_q == ST_FIN) begin
			out_left_q    <= yl_q;
			out_right_q   <= !stereo_q ? '0 : (hold_q ? cur_r_q : lerp_y);
			stream_done_q <= (od_inc >= out_count_q)
				|| (last_q && n_inc == RESULT_CNT_W'(MAX_RESULTS));
		end
		if (state_q == ST_LOOK) run_last_q <= !more;
	end

endmodule

@@ rtl/core/lir_checker.sv @@
// Port-level checks for the linear interpolation resampler.
// Bound to linear_interp_resampler; sees only its channel handshakes and flags.
module lir_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic run_last,
	input logic stream_done
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("Input ready while a result is offered.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("Input ready right after a frame was taken.");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stream_done) |-> run_last)
		else $error("Final stream item does not close its run.");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_last) |=> !in_ready)
		else $error("Input ready in the middle of a run.");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.run_last   (out_ch.run_last),
	.stream_done(out_ch.stream_done)
);

@@ verif/linear_interp_resampler_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for linear_interp_resampler: frames go in, and each output item
// is checked against a resampler model kept inside this file. Depends on lir_pkg and on
// the lir_in_if and lir_out_if interfaces.
module linear_interp_resampler_test;
	import lir_pkg::*;

	localparam int SB = 16;
	localparam int FCB = 24;
	localparam int CFG_W = (FCB > RATE_STEP_W) ? FCB : RATE_STEP_W;
	localparam int RANDOM_ITEMS = 260;
	localparam int DRAIN_CYCLES = 12;
	localparam int TAIL_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
		logic                 run_last;
		logic                 stream_done;
	} out_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	lir_in_if #(.SAMPLE_BITS(SB)) in_ch ();
	lir_out_if #(.SAMPLE_BITS(SB)) out_ch ();

	linear_interp_resampler #(
		.SAMPLE_BITS(SB),
		.FRAME_COUNT_BITS(FCB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #10 clk = ~clk;

	// Model copy of the registers and of the stream state.
	logic [RATE_STEP_W-1:0] step_reg = RATE_STEP_RESET;
	logic [CHAN_CNT_W-1:0] chan_reg = CHAN_CNT_RESET;
	logic [FCB-1:0] in_count_reg = 24'd1;
	logic [FCB-1:0] out_count_reg = '0;
	longint held_left = 0;
	longint held_right = 0;
	logic [FCB-1:0] frames_seen = '0;
	logic [39:0] out_position = '0;
	logic [FCB-1:0] outputs_made = '0;

	out_frame_t pending_outputs[$];
	bit idle_on = 1'b1;
	int error_count = 0;
	int frames_used = 0;
	int frames_ignored = 0;
	int results_checked = 0;
	int settings_used = 0;
	int quiet_cycles = 0;

	function automatic longint blend(input longint x0, input longint x1, input longint frac);
		return x0 + (((x1 - x0) * frac + 32768) >>> 16);
	endfunction

	task automatic resample_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		out_frame_t batch[MAX_RESULTS];
		bit stereo;
		bit is_last;
		bit more;
		longint k;
		longint cur_l;
		longint cur_r;
		longint ipos;
		longint frac;
		longint yl;
		longint yr;
		int n;
		stereo = (chan_reg == CHAN_STEREO);
		k = frames_seen;
		if (k >= in_count_reg) begin
			frames_ignored++;
		end else begin
			frames_used++;
			is_last = (k + 1 == in_count_reg);
			cur_l = l;
			if (stereo) begin
				cur_r = r;
			end else begin
				cur_r = 0;
			end
			n = 0;
			more = 1'b1;
			while (more && outputs_made < out_count_reg && n < MAX_RESULTS) begin
				ipos = out_position[39:16];
				frac = out_position[15:0];
				if (ipos < k) begin
					yl = blend(held_left, cur_l, frac);
					yr = blend(held_right, cur_r, frac);
				end else if (is_last) begin
					yl = cur_l;
					yr = cur_r;
				end else begin
					more = 1'b0;
				end
				if (more) begin
					batch[n].left = yl[SB-1:0];
					batch[n].right = stereo ? yr[SB-1:0] : '0;
					batch[n].run_last = 1'b0;
					batch[n].stream_done = 1'b0;
					n++;
					outputs_made = outputs_made + 1'b1;
					out_position = out_position + step_reg;
					if (outputs_made >= out_count_reg) begin
						batch[n-1].stream_done = 1'b1;
					end else if (is_last && n == MAX_RESULTS) begin
						batch[n-1].stream_done = 1'b1;
						outputs_made = out_count_reg;
					end
				end
			end
			if (n > 0) begin
				batch[n-1].run_last = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				pending_outputs.push_back(batch[i]);
			end
			held_left = cur_l;
			held_right = cur_r;
			frames_seen = k + 1;
		end
	endtask

	// Number of output positions that fall before the given frame, capped.
	function automatic longint positions_before(input logic [FCB-1:0] frame_end);
		longint lim;
		longint span;
		lim = {frame_end, 16'h0000};
		if (out_position >= lim) begin
			return 0;
		end
		if (step_reg == 0) begin
			return 200;
		end
		span = (lim - out_position + step_reg - 1) / step_reg;
		return (span > 200) ? 200 : span;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_RATE_STEP: step_reg = value[RATE_STEP_W-1:0];
			REG_CHANNEL_COUNT: chan_reg = value[CHAN_CNT_W-1:0];
			REG_IN_FRAME_COUNT: in_count_reg = value[FCB-1:0];
			REG_OUT_FRAME_COUNT: out_count_reg = value[FCB-1:0];
			default: ;
		endcase
	endtask

	task automatic start_run(input logic [RATE_STEP_W-1:0] rate, input logic [CHAN_CNT_W-1:0] chans,
		input int frames, input int extra);
		logic [FCB-1:0] frame_end;
		frame_end = frames_seen + frames;
		write_reg(REG_RATE_STEP, rate);
		write_reg(REG_CHANNEL_COUNT, chans);
		write_reg(REG_IN_FRAME_COUNT, frame_end);
		write_reg(REG_OUT_FRAME_COUNT, outputs_made + positions_before(frame_end) + extra);
		settings_used++;
	endtask

	task automatic send_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		int gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			in_ch.sample_left = $urandom;
			in_ch.sample_right = $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.sample_left = l;
		in_ch.sample_right = r;
		do @(posedge clk); while (!in_ch.ready);
		resample_frame(l, r);
	endtask

	task automatic lower_valid();
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		lower_valid();
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SB-1:0] random_sample();
		case ($urandom_range(0, 11))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_reset_state();
		// Reset values give no outputs; the second frame is past the end.
		send_frame(16'sh1234, 16'sh4321);
		send_frame(16'sh7FFF, 16'sh8000);
	endtask

	task automatic test_extremes();
		logic signed [SB-1:0] lefts[8];
		logic signed [SB-1:0] rights[8];
		lefts = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh4000,
			16'sh0001};
		rights = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000, 16'shC000,
			16'shFFFF};
		wait_idle();
		start_run(21'd98304, CHAN_STEREO, 8, 1);
		for (int i = 0; i < 8; i++) begin
			send_frame(lefts[i], rights[i]);
		end
	endtask

	task automatic test_upsample_cap();
		// The last frame needs more than the per-frame limit, so the stream is cut short.
		wait_idle();
		start_run(21'd2048, 2'd1, 3, 100);
		send_frame(16'sh7FFF, 16'sh0000);
		send_frame(16'sh8000, 16'sh0000);
		send_frame(16'sh1357, 16'sh0000);
	endtask

	task automatic test_late_outputs();
		// A step below the usual range leaves outputs behind the previous frame.
		wait_idle();
		start_run(21'd1024, 2'd0, 3, 0);
		send_frame(16'sh8000, 16'sh7FFF);
		send_frame(16'sh7FFF, 16'sh8000);
		send_frame(16'sh0100, 16'sh0200);
	endtask

	task automatic test_zero_step();
		wait_idle();
		start_run(21'd0, CHAN_STEREO, 2, 0);
		send_frame(16'sh2222, 16'shDDDD);
		send_frame(16'sh8000, 16'sh7FFF);
	endtask

	task automatic test_count_limits();
		wait_idle();
		idle_on = 1'b0;
		write_reg(REG_RATE_STEP, 24'd65536);
		write_reg(REG_CHANNEL_COUNT, 24'd3);
		write_reg(REG_IN_FRAME_COUNT, 24'hFFFFFF);
		write_reg(REG_OUT_FRAME_COUNT, 24'hFFFFFF);
		settings_used++;
		send_frame(16'sh7FFF, 16'sh1111);
		send_frame(16'sh8000, 16'sh2222);
		send_frame(16'sh0000, 16'sh3333);
		wait_idle();
		// With no input frames configured, every frame is dropped.
		write_reg(REG_IN_FRAME_COUNT, 24'd0);
		write_reg(REG_OUT_FRAME_COUNT, 24'd0);
		settings_used++;
		send_frame(16'sh5555, 16'shAAAA);
		send_frame(16'shAAAA, 16'sh5555);
		idle_on = 1'b1;
	endtask

	task automatic test_random_streams();
		int target;
		int run_index;
		int frames;
		int extra;
		logic [RATE_STEP_W-1:0] rate;
		target = frames_used + RANDOM_ITEMS;
		run_index = 0;
		while (frames_used < target) begin
			wait_idle();
			idle_on = (frames_used < target - 60) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 11))
				0, 1: rate = 21'd2048;
				2: rate = 21'd1048576;
				3: rate = 21'h1FFFFF;
				4: rate = $urandom_range(2048, 1048576);
				default: rate = $urandom_range(16384, 196608);
			endcase
			frames = (rate > 262144) ? $urandom_range(40, 64) : $urandom_range(4, 24);
			if (rate > 131072) begin
				extra = 0;
			end else if ($urandom_range(0, 7) == 0) begin
				extra = 80;
			end else begin
				extra = $urandom_range(0, 3);
			end
			start_run(rate, $urandom_range(0, 3), frames, extra);
			for (int i = 0; i < frames; i++) begin
				if (run_index % 3 == 0 && i == frames / 2) begin
					wait_drained();
				end
				send_frame(random_sample(), random_sample());
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) send_frame(random_sample(), random_sample());
			end
			run_index++;
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample_left = '0;
		in_ch.sample_right = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_extremes();
		test_upsample_cap();
		test_late_outputs();
		test_zero_step();
		test_count_limits();
		test_random_streams();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d frames in use and %0d dropped past the end of a stream,",
			frames_used, frames_ignored);
		$display("with %0d output items checked across %0d register settings.",
			results_checked, settings_used);
		if (error_count == 0) begin
			$display("linear_interp_resampler_test passed");
		end else begin
			$display("linear_interp_resampler_test failed");
		end
		$finish;
	end

	initial begin : sink_ready
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				stall_left = 0;
			end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else begin
				out_ch.ready = arst_n;
			end
		end
	end

	always @(posedge clk) begin
		out_frame_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_checked++;
			if (pending_outputs.size() == 0) begin
				error_count++;
				$display("%0t: unexpected item: expected none, actual left %0d right %0d",
					$time, out_ch.out_left, out_ch.out_right);
				$display("%0t: unexpected item: actual last %0b done %0b",
					$time, out_ch.run_last, out_ch.stream_done);
			end else begin
				want = pending_outputs.pop_front();
				if (out_ch.out_left !== want.left || out_ch.out_right !== want.right
					|| out_ch.run_last !== want.run_last
					|| out_ch.stream_done !== want.stream_done) begin
					error_count++;
					$display("%0t: mismatch: expected left %0d right %0d last %0b done %0b,",
						$time, want.left, want.right, want.run_last, want.stream_done);
					$display("%0t: mismatch: actual left %0d right %0d last %0b done %0b",
						$time, out_ch.out_left, out_ch.out_right, out_ch.run_last,
						out_ch.stream_done);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d results still expected", $time,
				WATCHDOG_LIMIT, pending_outputs.size());
			$display("linear_interp_resampler_test failed");
			$finish;
		end
	end

endmodule
